### hdl/ups_pkg.sv
package ups_pkg;

    // Power sequencer modes
    typedef enum logic [2:0] {
        MODE_WAIT_RELEASE = 3'd0,
        MODE_POWER_INIT   = 3'd1,
        MODE_MAIN_ON      = 3'd2,
        MODE_MAIN_FAIL    = 3'd3,
        MODE_SHUTDOWN     = 3'd4
    } power_mode_t;

    // Host event codes
    typedef enum logic [1:0] {
        HOST_EVT_NONE      = 2'd0,
        HOST_EVT_SHDN_REQ  = 2'd1,
        HOST_EVT_SHDN_DONE = 2'd2
    } host_event_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_MAIN_ON_MV     = 3'd0,
        CFG_MAIN_OFF_MV    = 3'd1,
        CFG_CHARGE_ON_MV   = 3'd2,
        CFG_CHARGE_OFF_MV  = 3'd3,
        CFG_MAIN_STABLE_MS = 3'd4,
        CFG_CHARGE_RES_MS  = 3'd5,
        CFG_LONG_PRESS_MS  = 3'd6,
        CFG_SHDN_DELAY_MS  = 3'd7
    } cfg_index_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Status flag masks
    localparam logic [3:0] FLAG_INIT     = 4'b0001;
    localparam logic [3:0] FLAG_SHUTDOWN = 4'b0010;
    localparam logic [3:0] FLAG_CHARGING = 4'b0100;
    localparam logic [3:0] FLAG_BATT_ERR = 4'b1000;

    // Mode counter constants
    localparam logic [7:0] COUNTER_WRAP       = 8'd2;
    localparam logic [7:0] COUNTER_ON_REQUEST = 8'd10;

    // Register reset values
    localparam logic [15:0] RST_MAIN_ON_MV     = 16'd4600;
    localparam logic [15:0] RST_MAIN_OFF_MV    = 16'd4300;
    localparam logic [15:0] RST_CHARGE_ON_MV   = 16'd4600;
    localparam logic [15:0] RST_CHARGE_OFF_MV  = 16'd4300;
    localparam logic [15:0] RST_MAIN_STABLE_MS = 16'd500;
    localparam logic [15:0] RST_CHARGE_RES_MS  = 16'd500;
    localparam logic [15:0] RST_LONG_PRESS_MS  = 16'd5000;
    localparam logic [31:0] RST_SHDN_DELAY_MS  = 32'd30000;

endpackage

### hdl/ups_power_sequencer_unit.sv
// UPS power sequencer.
// Input channel (s_*): one item per update step carrying a millisecond
// timestamp, the main supply voltage and button press/release events.
// Result channel (m_*): one item per input item with the pin levels
// (main, host, boost, long backup, charger), the power mode, status flags,
// the mode counter, a host event code and the keep-released pulse.
// Configuration: cfg_wr_en/cfg_wr_index/cfg_wr_data write one of eight
// thresholds and timers; write only while idle.
// Path: an accepted item lands in the input register; its result is
// registered with m_valid once the result slot is free or being drained.
// Throughput: one item per cycle unless m_ready stalls. The charge machine,
// button timing and sequencer all evaluate in one combinational pass
// between the input and output registers, and the state they update is
// written at the same edge as the result, so the next item sees it.
// Stall: when m_ready is low the result holds; the input register keeps
// accepting while the result slot is free or being drained, then s_ready
// drops until the output moves.
// Reset (aresetn low, synchronous): mode = power init, all pins off,
// stamps, timers, flags and counter cleared, registers at defaults.
module ups_power_sequencer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [ups_pkg::CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [ups_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_now_ms,
    input  logic [15:0] s_main_voltage_mv,
    input  logic        s_press_event,
    input  logic        s_release_event,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_main_power_on,
    output logic        m_host_enable,
    output logic        m_boost_on,
    output logic        m_backup_long_on,
    output logic        m_charge_on,
    output logic [2:0]  m_power_mode,
    output logic [3:0]  m_status_bits,
    output logic [7:0]  m_mode_count,
    output logic [1:0]  m_host_event,
    output logic        m_keep_released_pulse
);

    // ---------------- configuration registers ----------------
    logic [15:0] main_on_mv_reg, main_off_mv_reg;
    logic [15:0] charge_on_mv_reg, charge_off_mv_reg;
    logic [15:0] main_stable_ms_reg, charge_res_ms_reg, long_press_ms_reg;
    logic [31:0] shdn_delay_ms_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_on_mv_reg     <= ups_pkg::RST_MAIN_ON_MV;
            main_off_mv_reg    <= ups_pkg::RST_MAIN_OFF_MV;
            charge_on_mv_reg   <= ups_pkg::RST_CHARGE_ON_MV;
            charge_off_mv_reg  <= ups_pkg::RST_CHARGE_OFF_MV;
            main_stable_ms_reg <= ups_pkg::RST_MAIN_STABLE_MS;
            charge_res_ms_reg  <= ups_pkg::RST_CHARGE_RES_MS;
            long_press_ms_reg  <= ups_pkg::RST_LONG_PRESS_MS;
            shdn_delay_ms_reg  <= ups_pkg::RST_SHDN_DELAY_MS;
        end else if (cfg_wr_en) begin
            unique case (ups_pkg::cfg_index_t'(cfg_wr_index))
                ups_pkg::CFG_MAIN_ON_MV:     main_on_mv_reg     <= cfg_wr_data[15:0];
                ups_pkg::CFG_MAIN_OFF_MV:    main_off_mv_reg    <= cfg_wr_data[15:0];
                ups_pkg::CFG_CHARGE_ON_MV:   charge_on_mv_reg   <= cfg_wr_data[15:0];
                ups_pkg::CFG_CHARGE_OFF_MV:  charge_off_mv_reg  <= cfg_wr_data[15:0];
                ups_pkg::CFG_MAIN_STABLE_MS: main_stable_ms_reg <= cfg_wr_data[15:0];
                ups_pkg::CFG_CHARGE_RES_MS:  charge_res_ms_reg  <= cfg_wr_data[15:0];
                ups_pkg::CFG_LONG_PRESS_MS:  long_press_ms_reg  <= cfg_wr_data[15:0];
                ups_pkg::CFG_SHDN_DELAY_MS:  shdn_delay_ms_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic        in_valid_reg;
    logic [31:0] now_reg;
    logic [15:0] volt_reg;
    logic        press_reg, release_reg;
    logic        out_valid_reg;
    logic        advance;

    // item moves from the input register into the result register
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg     <= s_now_ms;
            volt_reg    <= s_main_voltage_mv;
            press_reg   <= s_press_event;
            release_reg <= s_release_event;
        end
    end

    // ---------------- block state ----------------
    ups_pkg::power_mode_t power_mode_reg, power_mode_next;
    logic        charge_mode_reg, charge_mode_next;
    logic [31:0] power_timer_reg, power_timer_next;
    logic [31:0] charge_timer_reg, charge_timer_next;
    logic [31:0] press_stamp_reg, press_stamp_next;
    logic [31:0] release_stamp_reg, release_stamp_next;
    logic [31:0] shdn_stamp_reg, shdn_stamp_next;
    logic [7:0]  mode_counter_reg, mode_counter_next;
    logic [3:0]  flag_reg, flag_next;
    logic        pin_main_reg, pin_main_next;
    logic        pin_host_reg, pin_host_next;
    logic        pin_boost_reg, pin_boost_next;
    logic        pin_long_reg, pin_long_next;
    logic        pin_charge_reg, pin_charge_next;

    // intermediate results after charge machine and button timing
    ups_pkg::power_mode_t mode_a;
    logic [3:0]  flags_a;
    logic        main_a, host_a, boost_a, long_a;
    ups_pkg::host_event_t host_evt;
    logic        keep_pulse;
    logic [31:0] held_ms;
    logic        press_done;

    // ---- charge enable machine, button timing, shutdown cut ----
    always_comb begin
        charge_mode_next  = charge_mode_reg;
        charge_timer_next = charge_timer_reg;
        pin_charge_next   = pin_charge_reg;
        flags_a           = flag_reg;
        mode_a            = power_mode_reg;
        mode_counter_next = mode_counter_reg;
        shdn_stamp_next   = shdn_stamp_reg;
        main_a            = pin_main_reg;
        host_a            = pin_host_reg;
        boost_a           = pin_boost_reg;
        long_a            = pin_long_reg;
        host_evt          = ups_pkg::HOST_EVT_NONE;
        keep_pulse        = 1'b0;

        // charger with hold-off on the way up, hysteresis on the way down
        if (charge_mode_reg) begin
            if (volt_reg < charge_off_mv_reg) begin
                pin_charge_next  = 1'b0;
                flags_a          = flags_a & ~ups_pkg::FLAG_CHARGING;
                charge_mode_next = 1'b0;
            end
        end else if (volt_reg < charge_on_mv_reg) begin
            charge_timer_next = now_reg;
        end else if ((now_reg - charge_timer_reg) >= {16'd0, charge_res_ms_reg}) begin
            pin_charge_next   = 1'b1;
            flags_a           = flags_a | ups_pkg::FLAG_CHARGING;
            charge_timer_next = now_reg;
            charge_mode_next  = 1'b1;
        end

        // button stamps; zero means unset
        press_stamp_next   = press_reg ? now_reg : press_stamp_reg;
        release_stamp_next = release_reg ? now_reg : release_stamp_reg;
        press_done = (press_stamp_next != 32'd0) && (release_stamp_next != 32'd0);
        held_ms    = release_stamp_next - press_stamp_next;

        if (press_done) begin
            if (held_ms > {16'd0, long_press_ms_reg}) begin
                if (power_mode_reg != ups_pkg::MODE_SHUTDOWN) begin
                    host_evt          = ups_pkg::HOST_EVT_SHDN_REQ;
                    flags_a           = ups_pkg::FLAG_SHUTDOWN;
                    mode_a            = ups_pkg::MODE_SHUTDOWN;
                    mode_counter_next = ups_pkg::COUNTER_ON_REQUEST;
                    shdn_stamp_next   = now_reg;
                end else begin
                    // cancel: pending stamp is kept
                    keep_pulse        = 1'b1;
                    flags_a           = ups_pkg::FLAG_INIT;
                    mode_a            = ups_pkg::MODE_WAIT_RELEASE;
                    mode_counter_next = 8'd0;
                end
            end else begin
                mode_counter_next = mode_counter_reg + 8'd1;
                if (mode_counter_next == ups_pkg::COUNTER_WRAP) begin
                    mode_counter_next = 8'd0;
                end
            end
            press_stamp_next   = 32'd0;
            release_stamp_next = 32'd0;
        end

        // delayed power cut; a request stamped at zero never fires
        if (mode_a == ups_pkg::MODE_SHUTDOWN && shdn_stamp_next != 32'd0 &&
            (now_reg - shdn_stamp_next) >= shdn_delay_ms_reg) begin
            host_evt        = ups_pkg::HOST_EVT_SHDN_DONE;
            main_a          = 1'b0;
            host_a          = 1'b0;
            boost_a         = 1'b0;
            long_a          = 1'b0;
            shdn_stamp_next = 32'd0;
        end
    end

    // ---- sequencer conditions ----
    logic main_low;     // below the switch-on threshold
    logic main_failed;  // below the failure threshold
    logic main_settled; // stability time elapsed
    assign main_low     = volt_reg < main_on_mv_reg;
    assign main_failed  = volt_reg < main_off_mv_reg;
    assign main_settled = (now_reg - power_timer_reg) >= {16'd0, main_stable_ms_reg};

    // ---- sequencer next state ----
    always_comb begin
        power_mode_next  = mode_a;
        power_timer_next = power_timer_reg;
        unique case (mode_a)
            ups_pkg::MODE_WAIT_RELEASE: begin
                power_timer_next = now_reg;
                if (release_reg) begin
                    power_mode_next = ups_pkg::MODE_POWER_INIT;
                end
            end
            ups_pkg::MODE_POWER_INIT,
            ups_pkg::MODE_MAIN_FAIL: begin
                if (main_low) begin
                    power_timer_next = now_reg;
                end else if (main_settled) begin
                    power_timer_next = now_reg;
                    power_mode_next  = ups_pkg::MODE_MAIN_ON;
                end
            end
            ups_pkg::MODE_MAIN_ON: begin
                if (main_failed) begin
                    power_timer_next = now_reg;
                    power_mode_next  = ups_pkg::MODE_MAIN_FAIL;
                end
            end
            default: ;
        endcase
    end

    // ---- sequencer outputs ----
    always_comb begin
        pin_main_next  = main_a;
        pin_host_next  = host_a;
        pin_boost_next = boost_a;
        pin_long_next  = long_a;
        flag_next      = flags_a;
        unique case (mode_a)
            ups_pkg::MODE_POWER_INIT: begin
                if (!main_low && main_settled) begin
                    pin_main_next  = 1'b1;
                    pin_host_next  = 1'b1;
                    pin_boost_next = 1'b1;
                    flag_next      = flags_a & ~ups_pkg::FLAG_INIT;
                end
            end
            ups_pkg::MODE_MAIN_ON: begin
                if (main_failed) begin
                    pin_main_next = 1'b0;
                    pin_long_next = 1'b1;
                    flag_next     = flags_a | ups_pkg::FLAG_BATT_ERR;
                end
            end
            ups_pkg::MODE_MAIN_FAIL: begin
                if (!main_low && main_settled) begin
                    pin_long_next = 1'b0;
                    pin_main_next = 1'b1;
                    flag_next     = flags_a & ~ups_pkg::FLAG_BATT_ERR;
                end
            end
            default: ;
        endcase
    end

    // ---- state update, once per item ----
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_mode_reg    <= ups_pkg::MODE_POWER_INIT;
            charge_mode_reg   <= 1'b0;
            power_timer_reg   <= 32'd0;
            charge_timer_reg  <= 32'd0;
            press_stamp_reg   <= 32'd0;
            release_stamp_reg <= 32'd0;
            shdn_stamp_reg    <= 32'd0;
            mode_counter_reg  <= 8'd0;
            flag_reg          <= 4'd0;
            pin_main_reg      <= 1'b0;
            pin_host_reg      <= 1'b0;
            pin_boost_reg     <= 1'b0;
            pin_long_reg      <= 1'b0;
            pin_charge_reg    <= 1'b0;
        end else if (advance) begin
            power_mode_reg    <= power_mode_next;
            charge_mode_reg   <= charge_mode_next;
            power_timer_reg   <= power_timer_next;
            charge_timer_reg  <= charge_timer_next;
            press_stamp_reg   <= press_stamp_next;
            release_stamp_reg <= release_stamp_next;
            shdn_stamp_reg    <= shdn_stamp_next;
            mode_counter_reg  <= mode_counter_next;
            flag_reg          <= flag_next;
            pin_main_reg      <= pin_main_next;
            pin_host_reg      <= pin_host_next;
            pin_boost_reg     <= pin_boost_next;
            pin_long_reg      <= pin_long_next;
            pin_charge_reg    <= pin_charge_next;
        end
    end

    // ---------------- result register ----------------
    logic        res_main_reg, res_host_reg, res_boost_reg, res_long_reg, res_charge_reg;
    logic [2:0]  res_mode_reg;
    logic [3:0]  res_status_reg;
    logic [7:0]  res_count_reg;
    logic [1:0]  res_event_reg;
    logic        res_keep_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_main_reg   <= pin_main_next;
            res_host_reg   <= pin_host_next;
            res_boost_reg  <= pin_boost_next;
            res_long_reg   <= pin_long_next;
            res_charge_reg <= pin_charge_next;
            res_mode_reg   <= power_mode_next;
            res_status_reg <= flag_next;
            res_count_reg  <= mode_counter_next;
            res_event_reg  <= host_evt;
            res_keep_reg   <= keep_pulse;
        end
    end

    assign m_valid               = out_valid_reg;
    assign m_main_power_on       = res_main_reg;
    assign m_host_enable         = res_host_reg;
    assign m_boost_on            = res_boost_reg;
    assign m_backup_long_on      = res_long_reg;
    assign m_charge_on           = res_charge_reg;
    assign m_power_mode          = res_mode_reg;
    assign m_status_bits         = res_status_reg;
    assign m_mode_count          = res_count_reg;
    assign m_host_event          = res_event_reg;
    assign m_keep_released_pulse = res_keep_reg;

endmodule

### hdl/ups_checker.sv
module ups_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_main_power_on,
    input logic        m_host_enable,
    input logic        m_boost_on,
    input logic        m_backup_long_on,
    input logic [2:0]  m_power_mode,
    input logic [3:0]  m_status_bits,
    input logic [7:0]  m_mode_count,
    input logic [1:0]  m_host_event,
    input logic        m_keep_released_pulse
);

    // stalled result holds its mode and event
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_power_mode) && $stable(m_host_event))
        else $error("result changed while stalled");

    // a completed cut leaves main, host, boost and long backup off in shutdown mode
    a_cut_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_host_event == ups_pkg::HOST_EVT_SHDN_DONE |->
            !m_main_power_on && !m_host_enable && !m_boost_on && !m_backup_long_on &&
            m_power_mode == ups_pkg::MODE_SHUTDOWN)
        else $error("power path on after shutdown cut");

    // a shutdown request sets shutdown mode, flag and counter
    a_request: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_host_event == ups_pkg::HOST_EVT_SHDN_REQ |->
            m_power_mode == ups_pkg::MODE_SHUTDOWN &&
            m_status_bits == ups_pkg::FLAG_SHUTDOWN &&
            m_mode_count == ups_pkg::COUNTER_ON_REQUEST)
        else $error("inconsistent shutdown request");

    // a cancel returns to init flag with a cleared counter and no event
    a_cancel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_keep_released_pulse |->
            m_status_bits == ups_pkg::FLAG_INIT && m_mode_count == 8'd0 &&
            m_host_event == ups_pkg::HOST_EVT_NONE &&
            (m_power_mode == ups_pkg::MODE_WAIT_RELEASE ||
             m_power_mode == ups_pkg::MODE_POWER_INIT))
        else $error("inconsistent shutdown cancel");

endmodule

bind ups_power_sequencer_unit ups_checker u_ups_checker (
    .aclk                  (aclk),
    .aresetn               (aresetn),
    .m_valid               (m_valid),
    .m_ready               (m_ready),
    .m_main_power_on       (m_main_power_on),
    .m_host_enable         (m_host_enable),
    .m_boost_on            (m_boost_on),
    .m_backup_long_on      (m_backup_long_on),
    .m_power_mode          (m_power_mode),
    .m_status_bits         (m_status_bits),
    .m_mode_count          (m_mode_count),
    .m_host_event          (m_host_event),
    .m_keep_released_pulse (m_keep_released_pulse)
);
